// ----- hdl/hbd_pkg.sv -----
// shared types, codes and byte classification for the http body deframer
// no dependencies
package hbd_pkg;

    // framing mode codes
    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FRAMING_MODE = 2'd0;
    localparam logic [1:0] REG_BODY_LENGTH  = 2'd1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int BODY_LEN_BITS  = 32;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;

    // classified byte travelling from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_item;

    typedef enum logic [5:0] {
        PH_DIGITS = 6'b000001,
        PH_EXT    = 6'b000010,
        PH_LF     = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_SKIP   = 6'b010000,
        PH_ERROR  = 6'b100000
    } t_phase;

    function automatic t_item classify(input logic [7:0] c);
        t_item r;
        r.data    = c;
        r.is_hex  = 1'b0;
        r.hex_val = 4'd0;
        r.is_cr   = (c == CHAR_CR);
        r.is_lf   = (c == CHAR_LF);
        if (c >= 8'h30 && c <= 8'h39) begin
            r.is_hex  = 1'b1;
            r.hex_val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // letters a-f and A-F share the low three bits
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return r;
    endfunction

endpackage

// ----- hdl/hbd_front.sv -----
// front end: takes raw bytes and classifies them for the back end
// depends on hbd_pkg
module hbd_front
    import hbd_pkg::*;
(
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_queue_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_item      o_item
);

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign o_item     = classify(i_data_byte);

endmodule

// ----- hdl/hbd_queue.sv -----
// short queue of classified bytes between front and back end
// depends on hbd_pkg
module hbd_queue
    import hbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_not_empty,
    output t_item o_item
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full      = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/hbd_back.sv -----
// back end: framing state, chunk size parser and output register
// depends on hbd_pkg
module hbd_back
    import hbd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_item_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_body_valid,
    output logic [7:0]                o_body_byte,
    output logic                      o_message_done,
    output logic                      o_frame_error
);

    logic [1:0]               r_mode;
    logic [BODY_LEN_BITS-1:0] r_body_length;
    t_phase                   r_phase, n_phase;
    logic [LENGTH_BITS-1:0]   r_chunk, n_chunk;
    logic                     r_digit_seen, n_digit_seen;
    logic [BODY_LEN_BITS-1:0] r_passed, n_passed;
    logic [1:0]               r_skip, n_skip;
    logic                     r_done, n_done;

    logic                     r_out_valid;
    logic                     r_body_valid;
    logic [7:0]               r_body_byte;
    logic                     r_message_done;
    logic                     r_frame_error;

    logic                     n_valid;
    logic [BODY_LEN_BITS-1:0] passed_inc;
    logic [LENGTH_BITS-1:0]   chunk_dec;

    assign o_pop      = i_item_valid && (!r_out_valid || !i_out_stall);
    assign passed_inc = r_passed + 1'b1;
    assign chunk_dec  = r_chunk - 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_chunk      = r_chunk;
        n_digit_seen = r_digit_seen;
        n_passed     = r_passed;
        n_skip       = r_skip;
        n_done       = r_done;
        n_valid      = 1'b0;
        if (r_done) begin
            n_valid = 1'b0;
        end else if (r_mode == MODE_LENGTH) begin
            n_valid = (r_passed < r_body_length);
            if (n_valid) begin
                n_passed = passed_inc;
                n_done   = (passed_inc == r_body_length);
            end else begin
                n_done = 1'b1;
            end
        end else if (r_mode == MODE_CHUNKED) begin
            case (r_phase)
                PH_DIGITS: begin
                    if (i_item.is_hex) begin
                        if (r_chunk[LENGTH_BITS-1 -: 4] != 4'd0) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_chunk      = {r_chunk[LENGTH_BITS-5:0], i_item.hex_val};
                            n_digit_seen = 1'b1;
                        end
                    end else if (!r_digit_seen) begin
                        n_phase = PH_ERROR;
                    end else if (i_item.is_cr) begin
                        n_phase = PH_LF;
                    end else begin
                        n_phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (i_item.is_cr) begin
                        n_phase = PH_LF;
                    end
                end
                PH_LF: begin
                    if (i_item.is_lf) begin
                        if (r_chunk == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (!i_item.is_cr) begin
                        n_phase = PH_EXT;
                    end
                end
                PH_DATA: begin
                    n_valid = 1'b1;
                    n_chunk = chunk_dec;
                    if (chunk_dec == '0) begin
                        n_phase = PH_SKIP;
                        n_skip  = 2'd2;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 1'b1;
                    if (n_skip == 2'd0) begin
                        n_phase      = PH_DIGITS;
                        n_chunk      = '0;
                        n_digit_seen = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end else begin
            // pass all, and the unused mode code behaves the same
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PASS;
            r_body_length <= '0;
            r_phase       <= PH_DIGITS;
            r_chunk       <= '0;
            r_digit_seen  <= 1'b0;
            r_passed      <= '0;
            r_skip        <= '0;
            r_done        <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FRAMING_MODE) begin
                r_mode       <= i_cfg_data[1:0];
                r_phase      <= PH_DIGITS;
                r_chunk      <= '0;
                r_digit_seen <= 1'b0;
                r_passed     <= '0;
                r_skip       <= '0;
                r_done       <= 1'b0;
            end else if (i_cfg_index == REG_BODY_LENGTH) begin
                r_body_length <= i_cfg_data[BODY_LEN_BITS-1:0];
            end
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_chunk      <= n_chunk;
            r_digit_seen <= n_digit_seen;
            r_passed     <= n_passed;
            r_skip       <= n_skip;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_body_valid   <= n_valid;
            r_body_byte    <= n_valid ? i_item.data : 8'd0;
            r_message_done <= n_done;
            r_frame_error  <= (r_mode == MODE_CHUNKED) && (n_phase == PH_ERROR);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_body_valid   = r_body_valid;
    assign o_body_byte    = r_body_byte;
    assign o_message_done = r_message_done;
    assign o_frame_error  = r_frame_error;

endmodule

// ----- hdl/http_body_deframer_top.sv -----
// http body deframer: pass-all, content-length and chunked transfer framing
// each byte is queued, then parsed, and its result held in the output register
// one byte per cycle while no result stall holds the parser in the back end
// a two-entry queue parts the byte classifier from the parser and output register
// reset (synchronous, active low) selects pass-all mode and clears all framing state
// depends on hbd_pkg, hbd_front, hbd_queue, hbd_back
module http_body_deframer_top
    import hbd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_data_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_body_valid,
    output logic [7:0]                o_body_byte,
    output logic                      o_message_done,
    output logic                      o_frame_error,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_not_empty;
    t_item front_item;
    t_item queue_item;

    assign o_cfg_ready = 1'b1;

    hbd_front u_front (
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_item       (front_item)
    );

    hbd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .i_pop       (pop),
        .o_full      (queue_full),
        .o_not_empty (queue_not_empty),
        .o_item      (queue_item)
    );

    hbd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_item_valid   (queue_not_empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_body_valid   (o_body_valid),
        .o_body_byte    (o_body_byte),
        .o_message_done (o_message_done),
        .o_frame_error  (o_frame_error)
    );

endmodule

// ----- tb/sv/body_checker.sv -----
// body_checker: follows the byte, register and result transfers of the http body deframer,
// predicts every result from its own copy of the framing state and compares in order
// depends on hbd_pkg
module body_checker
    import hbd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_body_valid,
    input  logic [7:0]                i_body_byte,
    input  logic                      i_message_done,
    input  logic                      i_frame_error,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_pending,
    output int                        o_errors,
    output int                        o_results,
    output int                        o_payload,
    output int                        o_done_seen,
    output int                        o_error_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       message_done;
        logic       frame_error;
    } t_body_result;

    // framing registers and state as the block should hold them
    logic [1:0]             framing;
    logic [BODY_LEN_BITS-1:0] declared_len;
    t_phase                 phase;
    logic [LENGTH_BITS-1:0] chunk_left;
    logic                   digit_seen;
    logic [31:0]            passed;
    logic [1:0]             skip_left;
    logic                   complete;

    t_body_result expected_body[$];
    t_body_result predicted;
    t_body_result oldest;
    t_body_result observed;
    int           errors;
    int           results;
    int           payload;
    int           done_seen;
    int           error_seen;

    initial begin
        errors     = 0;
        results    = 0;
        payload    = 0;
        done_seen  = 0;
        error_seen = 0;
    end

    // {is hex, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, 4'(c - "0")};
        end
        if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end
        if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic void restart_framing();
        phase      = PH_DIGITS;
        chunk_left = '0;
        digit_seen = 1'b0;
        passed     = '0;
        skip_left  = '0;
        complete   = 1'b0;
    endfunction

    task automatic deframe_byte(input logic [7:0] c, output t_body_result r);
        logic [4:0] hx;
        r  = '0;
        hx = hex_digit(c);
        if (complete) begin
            // body finished: byte dropped
        end else if (framing == MODE_LENGTH) begin
            if (passed < declared_len) begin
                r.body_valid = 1'b1;
                r.body_byte  = c;
                passed       = passed + 32'd1;
            end
            if (passed >= declared_len) begin
                complete = 1'b1;
            end
        end else if (framing == MODE_CHUNKED) begin
            case (phase)
                PH_DIGITS: begin
                    if (hx[4]) begin
                        // a digit that would push bits out of the counter is an error
                        if (chunk_left[LENGTH_BITS-1 -: 4] != 4'd0) begin
                            phase = PH_ERROR;
                        end else begin
                            chunk_left = {chunk_left[LENGTH_BITS-5:0], hx[3:0]};
                            digit_seen = 1'b1;
                        end
                    end else if (!digit_seen) begin
                        phase = PH_ERROR;
                    end else if (c == CHAR_CR) begin
                        phase = PH_LF;
                    end else begin
                        phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (c == CHAR_CR) begin
                        phase = PH_LF;
                    end
                end
                PH_LF: begin
                    if (c == CHAR_LF) begin
                        if (chunk_left == '0) begin
                            complete = 1'b1;
                        end else begin
                            phase = PH_DATA;
                        end
                    end else if (c != CHAR_CR) begin
                        phase = PH_EXT;
                    end
                end
                PH_DATA: begin
                    r.body_valid = 1'b1;
                    r.body_byte  = c;
                    chunk_left   = chunk_left - 1'b1;
                    if (chunk_left == '0) begin
                        phase     = PH_SKIP;
                        skip_left = 2'd2;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0) begin
                        phase      = PH_DIGITS;
                        chunk_left = '0;
                        digit_seen = 1'b0;
                    end
                end
                default: begin
                    phase = PH_ERROR;
                end
            endcase
        end else begin
            // pass-all, and the spare mode code behaves the same
            r.body_valid = 1'b1;
            r.body_byte  = c;
        end
        r.message_done = complete;
        r.frame_error  = (framing == MODE_CHUNKED) && (phase == PH_ERROR);
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] seen);
        if (want !== seen) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            framing      = MODE_PASS;
            declared_len = '0;
            restart_framing();
            expected_body.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                observed = '{i_body_valid, i_body_byte, i_message_done, i_frame_error};
                results++;
                if (observed.body_valid === 1'b1) payload++;
                if (observed.message_done === 1'b1) done_seen++;
                if (observed.frame_error === 1'b1) error_seen++;
                if (expected_body.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing outstanding, expected none, %s",
                             $time, $sformatf("got valid %0b byte %0h done %0b error %0b",
                             observed.body_valid, observed.body_byte,
                             observed.message_done, observed.frame_error));
                end else begin
                    oldest = expected_body.pop_front();
                    compare_field("body_valid", 8'(oldest.body_valid), 8'(observed.body_valid));
                    compare_field("body_byte", oldest.body_byte, observed.body_byte);
                    compare_field("message_done", 8'(oldest.message_done),
                                  8'(observed.message_done));
                    compare_field("frame_error", 8'(oldest.frame_error),
                                  8'(observed.frame_error));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_FRAMING_MODE) begin
                    framing = i_cfg_data[1:0];
                    restart_framing();
                end else if (i_cfg_index == REG_BODY_LENGTH) begin
                    declared_len = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_data_byte, predicted);
                expected_body.push_back(predicted);
            end
        end
        o_pending    <= expected_body.size();
        o_errors     <= errors;
        o_results    <= results;
        o_payload    <= payload;
        o_done_seen  <= done_seen;
        o_error_seen <= error_seen;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench top for http_body_deframer_top: clock, reset, register writes and byte traffic
// in all framing modes, with random idling on both sides; results are judged by body_checker
// depends on hbd_pkg, body_checker and the deframer rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbd_pkg::*;

    localparam int CHUNK_BITS   = 32;
    localparam int TARGET_BYTES = 2100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_SLACK  = 4;

    // mode code with no meaning of its own, and a register index that is not mapped
    localparam logic [1:0]                MODE_RESERVED = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE     = 2'd3;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [7:0]                i_data_byte;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_body_valid;
    logic [7:0]                o_body_byte;
    logic                      o_message_done;
    logic                      o_frame_error;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    int pending_results;
    int fail_count;
    int results_seen;
    int payload_seen;
    int done_seen;
    int error_seen;

    int cycle_count = 0;
    int bytes_sent  = 0;
    int setups      = 0;
    int hold_requests = 0;
    bit jitter_on   = 1'b1;

    http_body_deframer_top #(
        .LENGTH_BITS(CHUNK_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_body_valid   (o_body_valid),
        .o_body_byte    (o_body_byte),
        .o_message_done (o_message_done),
        .o_frame_error  (o_frame_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    body_checker #(
        .LENGTH_BITS(CHUNK_BITS)
    ) u_body_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_body_valid   (o_body_valid),
        .i_body_byte    (o_body_byte),
        .i_message_done (o_message_done),
        .i_frame_error  (o_frame_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_results),
        .o_errors       (fail_count),
        .o_results      (results_seen),
        .o_payload      (payload_seen),
        .o_done_seen    (done_seen),
        .o_error_seen   (error_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at the cycle limit");
        $display("testbench: done, errors");
        $finish;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= jitter_on && ($urandom_range(99) < 38);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (jitter_on && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        if (nib < 4'd10) begin
            return "0" + 8'(nib);
        end
        // letters in either case
        base = $urandom_range(1) ? "a" : "A";
        return base + 8'(nib - 4'd10);
    endfunction

    task automatic send_size_line(input logic [31:0] size);
        int top_nib;
        repeat ($urandom_range(0, 2)) send_byte("0");
        top_nib = 7;
        while (top_nib > 0 && size[top_nib*4 +: 4] == 4'd0) top_nib--;
        for (int k = top_nib; k >= 0; k--) send_byte(hex_char(size[k*4 +: 4]));
        if ($urandom_range(2) == 0) begin
            send_byte(";");
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
            // a lone cr inside the extension must not end the line
            if ($urandom_range(1) == 0) begin
                send_byte(CHAR_CR);
                send_byte("q");
            end
        end
        if ($urandom_range(5) == 0) send_byte(CHAR_CR);
        send_crlf();
    endtask

    task automatic send_chunked_traffic();
        int          kind;
        logic [31:0] size;
        kind = $urandom_range(99);
        if (kind < 70) begin
            repeat ($urandom_range(1, 4)) begin
                size = ($urandom_range(7) == 0) ? 32'd1 : 32'($urandom_range(1, 20));
                send_size_line(size);
                repeat (size) send_byte(8'($urandom));
                // the trailer is skipped whatever it holds
                if ($urandom_range(4) == 0) begin
                    send_byte(8'($urandom));
                    send_byte(8'($urandom));
                end else begin
                    send_crlf();
                end
            end
            send_size_line(32'd0);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        end else if (kind < 78) begin
            // size line opening with something other than a hex digit
            case ($urandom_range(3))
                0: send_byte(CHAR_CR);
                1: send_byte(CHAR_LF);
                2: send_byte(";");
                default: send_byte(8'h80 | 8'($urandom));
            endcase
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (kind < 86) begin
            // nine significant digits: one more than the counter holds
            send_byte(hex_char(4'($urandom_range(1, 15))));
            repeat (8) send_byte(hex_char(4'($urandom)));
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (kind < 92) begin
            // largest size the counter takes, cut short
            send_size_line(32'hffff_ffff);
            repeat ($urandom_range(10, 30)) send_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(10, 30)) send_byte(8'($urandom));
        end
    endtask

    // stop offering bytes until every outstanding result has been transferred
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [31:0] length,
                             input bit poke_spare);
        logic [31:0] mode_word;
        drain();
        mode_word      = $urandom;
        mode_word[1:0] = mode;
        write_reg(REG_BODY_LENGTH, length);
        if (poke_spare) write_reg(REG_SPARE, $urandom);
        write_reg(REG_FRAMING_MODE, mode_word);
        i_cfg_valid <= 1'b0;
        setups++;
    endtask

    initial begin
        int          pick;
        logic [31:0] length;
        int          burst;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-all straight out of reset
        send_byte(8'h00);
        send_byte(8'hff);
        configure(MODE_RESERVED, 32'hffff_ffff, 1'b1);
        send_byte(8'ha5);
        // zero content length: first byte dropped and body complete
        configure(MODE_LENGTH, 32'd0, 1'b0);
        send_byte(8'h11);
        send_byte(8'h22);
        configure(MODE_LENGTH, 32'd2, 1'b0);
        send_text("abc");
        // extension, cr without lf, trailer, zero chunk, then a byte after completion
        configure(MODE_CHUNKED, 32'd0, 1'b0);
        send_text("1;e");
        send_byte(CHAR_CR);
        send_text("z");
        send_byte(CHAR_CR);
        send_crlf();
        send_text("Qxy0");
        send_crlf();
        send_text("k");
        // empty size line, then a byte dropped under the error
        configure(MODE_CHUNKED, 32'd0, 1'b0);
        send_byte(CHAR_CR);
        send_byte("5");

        // long hold-off on the result side while bytes keep coming
        configure(MODE_PASS, $urandom, 1'b0);
        jitter_on = 1'b0;
        hold_requests++;
        repeat (40) send_byte(8'($urandom));
        jitter_on = 1'b1;

        while (bytes_sent < TARGET_BYTES) begin
            // a run of setups with no idling on either side
            jitter_on = !(setups >= 20 && setups < 28);
            pick = $urandom_range(99);
            if (pick < 45) begin
                configure(MODE_CHUNKED, $urandom, $urandom_range(9) == 0);
                send_chunked_traffic();
            end else if (pick < 75) begin
                pick = $urandom_range(99);
                if (pick < 10) length = 32'd0;
                else if (pick < 15) length = 32'd1;
                else if (pick < 20) length = 32'hffff_ffff;
                else if (pick < 25) length = $urandom;
                else length = 32'($urandom_range(2, 40));
                burst = (length > 32'd40) ? 40 : int'(length);
                configure(MODE_LENGTH, length, $urandom_range(9) == 0);
                repeat (burst + $urandom_range(0, 4)) send_byte(8'($urandom));
            end else if (pick < 92) begin
                configure(MODE_PASS, $urandom, $urandom_range(9) == 0);
                repeat ($urandom_range(10, 40)) send_byte(8'($urandom));
            end else begin
                configure(MODE_RESERVED, $urandom, $urandom_range(9) == 0);
                repeat ($urandom_range(10, 40)) send_byte(8'($urandom));
            end
        end

        drain();
        $display("covered %0d bytes over %0d framing setups: pass-all, content-length, chunked",
                 bytes_sent, setups);
        $display("%0d results checked, %0d payload bytes, %0d marked complete, %0d in error",
                 results_seen, payload_seen, done_seen, error_seen);
        if (fail_count == 0 && pending_results == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
